[rtl/brle_pkg.sv]
// Package for the BMP RLE8/RLE4 pixel decoder.
// Holds field widths, mode, escape and register codes, phase and descriptor types.
// No dependencies.
package brle_pkg;

  localparam int COL_W      = 13;
  localparam int ROW_W      = 14;
  localparam int CNT_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int ADDR_W     = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int NIB_W      = 4;

  localparam int MAX_WIDTH            = 4096;
  localparam int MAX_HEIGHT           = 4096;
  localparam int PALETTE_ENTRIES_DEF  = 256;

  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = CFG_DATA_W'(1);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = CFG_DATA_W'(1);

  localparam logic [MODE_W-1:0] MODE_PAL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE = 2'd2;

  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

  typedef enum logic [6:0] {
    PH_COUNT  = 7'b0000001,
    PH_COLOR  = 7'b0000010,
    PH_ESCAPE = 7'b0000100,
    PH_DX     = 7'b0001000,
    PH_DY     = 7'b0010000,
    PH_ABS    = 7'b0100000,
    PH_PAD    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                     valid;
    logic                     eoi;
    logic                     oor;
    logic                     use_b;
    logic [CNT_W-1:0]         n;
    logic [COL_W-1:0]         col;
    logic signed [ROW_W-1:0]  row;
    logic [CFG_DATA_W-1:0]    width;
  } desc_t;

  typedef struct packed {
    logic               wr_en;
    logic [BYTE_W-1:0]  wr_idx;
    logic [COLOR_W-1:0] wr_data;
    logic               rd_en;
    logic [BYTE_W-1:0]  rd_idx_a;
    logic [NIB_W-1:0]   rd_idx_b;
  } pal_req_t;

endpackage

[rtl/brle_palette.sv]
// Palette memory: one write port, two registered read ports.
// Depends on brle_pkg for widths and the request struct.
module brle_palette import brle_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  pal_req_t           req,
  output logic [COLOR_W-1:0] rd_data_a,
  output logic [COLOR_W-1:0] rd_data_b,
  output logic               rd_ok_a
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] rd_a_r;
  logic [COLOR_W-1:0] rd_b_r;
  logic               ok_a_r;

  always_ff @(posedge clk) begin
    if (req.wr_en && (32'(req.wr_idx) < PALETTE_ENTRIES)) begin
      mem[req.wr_idx[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a_r <= mem[req.rd_idx_a[AW-1:0]];
      rd_b_r <= mem[AW'(req.rd_idx_b)];
      ok_a_r <= 32'(req.rd_idx_a) < PALETTE_ENTRIES;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;
  assign rd_ok_a   = ok_a_r;

endmodule

[rtl/brle_ctrl.sv]
// Stream parser: configuration registers, position, phase and run counters.
// Produces run descriptors and palette requests. Depends on brle_pkg.
module brle_ctrl import brle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  take,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [BYTE_W-1:0]     in_palette_index,
  input  logic [COLOR_W-1:0]    in_palette_color,
  output desc_t                 desc,
  output pal_req_t              pal_req
);

  logic [CFG_DATA_W-1:0]   width_r, height_r;
  logic                    nibble_r;
  logic [COL_W-1:0]        column_r, column_nxt;
  logic signed [ROW_W-1:0] row_r, row_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [CNT_W-1:0]        run_len_r, run_len_nxt;
  logic [CNT_W-1:0]        abs_rem_r, abs_rem_nxt;
  logic                    pad_r, pad_nxt;
  logic                    finished_r, finished_nxt;

  logic [CFG_DATA_W-1:0]   eff_w, eff_h;
  logic signed [ROW_W-1:0] start_row;
  logic                    emit;
  logic [CNT_W-1:0]        emit_n;
  logic [CNT_W-1:0]        abs_n;
  logic [CNT_W:0]          b_inc;
  logic [COL_W:0]          run_end;

  function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] c,
                                                input logic [CNT_W-1:0] n);
    logic [COL_W:0] s;
    s = {1'b0, c} + (COL_W+1)'(n);
    return s[COL_W] ? COL_MAX : s[COL_W-1:0];
  endfunction

  function automatic logic signed [ROW_W-1:0] row_sub(input logic signed [ROW_W-1:0] r,
                                                       input logic [CNT_W-1:0] n);
    logic signed [ROW_W:0] d;
    d = {r[ROW_W-1], r} - $signed((ROW_W+1)'(n));
    return (d < $signed({ROW_MIN[ROW_W-1], ROW_MIN})) ? ROW_MIN : d[ROW_W-1:0];
  endfunction

  always_comb begin
    eff_w = width_r;
    if (width_r == '0) begin
      eff_w = CFG_DATA_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = CFG_DATA_W'(MAX_WIDTH);
    end
    eff_h = height_r;
    if (height_r == '0) begin
      eff_h = CFG_DATA_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = CFG_DATA_W'(MAX_HEIGHT);
    end
  end

  assign start_row = $signed({1'b0, eff_h - CFG_DATA_W'(1)});
  assign b_inc     = {1'b0, in_data_byte} + (CNT_W+1)'(1);
  assign abs_n     = !nibble_r ? CNT_W'(1) :
                     (abs_rem_r >= CNT_W'(2)) ? CNT_W'(2) : abs_rem_r;
  assign run_end   = {1'b0, column_r} + (COL_W+1)'(emit_n);

  always_comb begin
    column_nxt   = column_r;
    row_nxt      = row_r;
    phase_nxt    = phase_r;
    run_len_nxt  = run_len_r;
    abs_rem_nxt  = abs_rem_r;
    pad_nxt      = pad_r;
    finished_nxt = finished_r;
    emit         = 1'b0;
    emit_n       = '0;
    desc         = '0;
    pal_req      = '0;
    pal_req.wr_idx   = in_palette_index;
    pal_req.wr_data  = in_palette_color;
    pal_req.rd_idx_a = nibble_r ? BYTE_W'(in_data_byte[BYTE_W-1:NIB_W]) : in_data_byte;
    pal_req.rd_idx_b = in_data_byte[NIB_W-1:0];
    if (take) begin
      case (in_mode)
        MODE_PAL: begin
          pal_req.wr_en = 1'b1;
        end
        MODE_START: begin
          column_nxt   = '0;
          row_nxt      = start_row;
          phase_nxt    = PH_COUNT;
          run_len_nxt  = '0;
          abs_rem_nxt  = '0;
          pad_nxt      = 1'b0;
          finished_nxt = 1'b0;
        end
        MODE_BYTE: begin
          if (!finished_r) begin
            case (phase_r)
              PH_COUNT: begin
                if (in_data_byte != '0) begin
                  run_len_nxt = in_data_byte;
                  phase_nxt   = PH_COLOR;
                end else begin
                  phase_nxt = PH_ESCAPE;
                end
              end
              PH_COLOR: begin
                emit          = 1'b1;
                emit_n        = run_len_r;
                desc.use_b    = nibble_r;
                pal_req.rd_en = 1'b1;
                phase_nxt     = PH_COUNT;
              end
              PH_ESCAPE: begin
                phase_nxt = PH_COUNT;
                if (in_data_byte == ESC_EOL) begin
                  column_nxt = '0;
                  row_nxt    = row_sub(row_r, CNT_W'(1));
                end else if (in_data_byte == ESC_EOB) begin
                  finished_nxt = 1'b1;
                  desc.valid   = 1'b1;
                  desc.eoi     = 1'b1;
                end else if (in_data_byte == ESC_DELTA) begin
                  phase_nxt = PH_DX;
                end else begin
                  abs_rem_nxt = in_data_byte;
                  pad_nxt     = nibble_r ? b_inc[1] : in_data_byte[0];
                  phase_nxt   = PH_ABS;
                end
              end
              PH_DX: begin
                column_nxt = col_add(column_r, in_data_byte);
                phase_nxt  = PH_DY;
              end
              PH_DY: begin
                row_nxt   = row_sub(row_r, in_data_byte);
                phase_nxt = PH_COUNT;
              end
              PH_ABS: begin
                emit          = 1'b1;
                emit_n        = abs_n;
                desc.use_b    = nibble_r && (abs_n == CNT_W'(2));
                pal_req.rd_en = 1'b1;
                abs_rem_nxt   = abs_rem_r - abs_n;
                if (abs_rem_r == abs_n) begin
                  phase_nxt = pad_r ? PH_PAD : PH_COUNT;
                end
              end
              PH_PAD: begin
                pad_nxt   = 1'b0;
                phase_nxt = PH_COUNT;
              end
              default: begin
                phase_nxt = PH_COUNT;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    if (emit) begin
      desc.valid = 1'b1;
      column_nxt = col_add(column_r, emit_n);
    end
    desc.n     = emit_n;
    desc.col   = column_r;
    desc.row   = row_r;
    desc.width = eff_w;
    desc.oor   = (row_r < 0) || (row_r >= $signed({1'b0, eff_h})) ||
                 (run_end > {1'b0, eff_w});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      nibble_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_NIBBLE: nibble_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      row_r      <= $signed(ROW_W'(HEIGHT_RST - CFG_DATA_W'(1)));
      phase_r    <= PH_COUNT;
      run_len_r  <= '0;
      abs_rem_r  <= '0;
      pad_r      <= 1'b0;
      finished_r <= 1'b0;
    end else begin
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      phase_r    <= phase_nxt;
      run_len_r  <= run_len_nxt;
      abs_rem_r  <= abs_rem_nxt;
      pad_r      <= pad_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

[rtl/brle_emit.sv]
// Run output stage: holds a descriptor while the palette read completes,
// forms the linear address and drives the output register. Depends on brle_pkg.
module brle_emit import brle_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  desc_t              desc,
  input  logic [COLOR_W-1:0] rd_data_a,
  input  logic [COLOR_W-1:0] rd_data_b,
  input  logic               rd_ok_a,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  out_start_address,
  output logic [CNT_W-1:0]   out_pixel_count,
  output logic [COLOR_W-1:0] out_first_color,
  output logic [COLOR_W-1:0] out_second_color,
  output logic               out_end_of_image,
  output logic               out_out_of_range
);

  logic                s1_valid_r, s1_valid_nxt;
  desc_t               s1_r;
  logic                s1_adv;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [COLOR_W-1:0]  c1_r, c1_nxt;
  logic [COLOR_W-1:0]  c2_r, c2_nxt;
  logic                eoi_r;
  logic                oor_r;
  logic [ADDR_W-1:0]   row_ext, w_ext;
  logic [2*ADDR_W-1:0] prod;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  assign row_ext  = ADDR_W'(s1_r.row);
  assign w_ext    = ADDR_W'(s1_r.width);
  assign prod     = row_ext * w_ext;

  always_comb begin
    addr_nxt = prod[ADDR_W-1:0] + ADDR_W'(s1_r.col);
    c1_nxt   = rd_ok_a ? rd_data_a : '0;
    c2_nxt   = s1_r.use_b ? rd_data_b : c1_nxt;
    if (s1_r.eoi) begin
      addr_nxt = '0;
      c1_nxt   = '0;
      c2_nxt   = '0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take && desc.valid) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && desc.valid) begin
      s1_r <= desc;
    end
    if (s1_adv) begin
      addr_r <= addr_nxt;
      cnt_r  <= s1_r.n;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      eoi_r  <= s1_r.eoi;
      oor_r  <= s1_r.oor && !s1_r.eoi;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_start_address = addr_r;
  assign out_pixel_count   = cnt_r;
  assign out_first_color   = c1_r;
  assign out_second_color  = c2_r;
  assign out_end_of_image  = eoi_r;
  assign out_out_of_range  = oor_r;

endmodule

[rtl/bmp_rle_pixel_decoder_top.sv]
// Top level of the BMP RLE8/RLE4 pixel decoder.
// Instantiates brle_ctrl, brle_palette and brle_emit; depends on brle_pkg.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid/in_ready      mode, data_byte, palette_index, palette_color
//   out_     out  out_valid/out_ready    start_address, pixel_count, colours, flags
//   cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle while in_ready is high; a run write enters the read stage
// (palette read at the transfer edge), then multiply-add into the output register.
// Reset is synchronous, active low; the palette is not cleared.
// in_ready drops only while both the read stage and the output register are full
// and out_ready is low. cfg_ready is always high.
module bmp_rle_pixel_decoder_top import brle_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [BYTE_W-1:0]     in_palette_index,
  input  logic [COLOR_W-1:0]    in_palette_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_start_address,
  output logic [CNT_W-1:0]      out_pixel_count,
  output logic [COLOR_W-1:0]    out_first_color,
  output logic [COLOR_W-1:0]    out_second_color,
  output logic                  out_end_of_image,
  output logic                  out_out_of_range
);

  logic               take;
  desc_t              desc;
  pal_req_t           pal_req;
  logic [COLOR_W-1:0] rd_data_a, rd_data_b;
  logic               rd_ok_a;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  brle_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .take             (take),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .in_palette_index (in_palette_index),
    .in_palette_color (in_palette_color),
    .desc             (desc),
    .pal_req          (pal_req)
  );

  brle_palette #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk       (clk),
    .req       (pal_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .rd_ok_a   (rd_ok_a)
  );

  brle_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .take              (take),
    .desc              (desc),
    .rd_data_a         (rd_data_a),
    .rd_data_b         (rd_data_b),
    .rd_ok_a           (rd_ok_a),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_start_address (out_start_address),
    .out_pixel_count   (out_pixel_count),
    .out_first_color   (out_first_color),
    .out_second_color  (out_second_color),
    .out_end_of_image  (out_end_of_image),
    .out_out_of_range  (out_out_of_range)
  );

endmodule

[rtl/brle_port_checker.sv]
// Port-level checker for the BMP RLE decoder top level, with its bind.
// Depends on brle_pkg for port widths.
module brle_port_checker import brle_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ADDR_W-1:0]  out_start_address,
  input logic [CNT_W-1:0]   out_pixel_count,
  input logic [COLOR_W-1:0] out_first_color,
  input logic               out_end_of_image,
  input logic               out_out_of_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_address) &&
      $stable(out_pixel_count) && $stable(out_first_color))
    else $error("output transfer changed while stalled");

  a_eoi_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_image |-> out_pixel_count == '0 &&
      out_start_address == '0 && !out_out_of_range && out_first_color == '0)
    else $error("end marker carries run data");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_image |-> out_pixel_count != '0)
    else $error("run write with zero pixels");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind bmp_rle_pixel_decoder_top brle_port_checker u_port_checker (.*);

[sim/bmp_rle_pixel_decoder_top_test.sv]
// Self-checking testbench for bmp_rle_pixel_decoder_top: loads the palette, streams RLE8 and
// RLE4 bytes under several image geometries and checks every run write against a prediction.
// Depends on brle_pkg and the decoder RTL.
module bmp_rle_pixel_decoder_top_test;
  import brle_pkg::*;

  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam logic [BYTE_W-1:0] ESC_LEAD = 8'd0;
  localparam int PAL_DEPTH = 256;
  localparam int STALL_LIMIT = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS = 40;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   count;
    logic [COLOR_W-1:0] first;
    logic [COLOR_W-1:0] second;
    logic               eoi;
    logic               oor;
  } run_write_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [MODE_W-1:0]     in_mode;
  logic [BYTE_W-1:0]     in_data_byte;
  logic [BYTE_W-1:0]     in_palette_index;
  logic [COLOR_W-1:0]    in_palette_color;
  logic                  out_valid;
  logic                  out_ready;
  logic [ADDR_W-1:0]     out_start_address;
  logic [CNT_W-1:0]      out_pixel_count;
  logic [COLOR_W-1:0]    out_first_color;
  logic [COLOR_W-1:0]    out_second_color;
  logic                  out_end_of_image;
  logic                  out_out_of_range;

  run_write_t            pending_writes[$];
  logic [COLOR_W-1:0]    pal_mem [PAL_DEPTH];
  logic [CFG_DATA_W-1:0] cfg_width;
  logic [CFG_DATA_W-1:0] cfg_height;
  bit                    cfg_nibble;
  phase_t                cur_phase;
  int                    cur_col;
  int                    cur_row;
  int                    run_len;
  int                    abs_left;
  bit                    pad_flag;
  bit                    done_flag;
  bit                    steady;
  int                    mismatches;
  int                    stall_cycles;
  int                    rdy_wait;
  int                    items_sent;

  bmp_rle_pixel_decoder_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_data_byte      (in_data_byte),
    .in_palette_index  (in_palette_index),
    .in_palette_color  (in_palette_color),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_start_address (out_start_address),
    .out_pixel_count   (out_pixel_count),
    .out_first_color   (out_first_color),
    .out_second_color  (out_second_color),
    .out_end_of_image  (out_end_of_image),
    .out_out_of_range  (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int used_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return cfg_width;
  endfunction

  function automatic int used_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic int abs_bytes(int count);
    return cfg_nibble ? (count + 1) / 2 : count;
  endfunction

  function automatic void restart_image();
    cur_col = 0;
    cur_row = used_height() - 1;
    cur_phase = PH_COUNT;
    run_len = 0;
    abs_left = 0;
    pad_flag = 1'b0;
    done_flag = 1'b0;
  endfunction

  function automatic void advance_col(int n);
    cur_col += n;
    if (cur_col > int'(COL_MAX)) cur_col = int'(COL_MAX);
  endfunction

  function automatic void drop_rows(int n);
    cur_row -= n;
    if (cur_row < int'(ROW_MIN)) cur_row = int'(ROW_MIN);
  endfunction

  function automatic void push_run(int n, logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2);
    run_write_t w;
    int lin;
    lin = cur_col + cur_row * used_width();
    w.addr = lin[ADDR_W-1:0];
    w.count = CNT_W'(n);
    w.first = c1;
    w.second = c2;
    w.eoi = 1'b0;
    w.oor = cur_row < 0 || cur_row >= used_height() || cur_col + n > used_width();
    pending_writes.push_back(w);
    advance_col(n);
  endfunction

  function automatic void decode_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] b,
                                      logic [BYTE_W-1:0] idx, logic [COLOR_W-1:0] color);
    int n;
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
    run_write_t eob;
    if (mode == MODE_PAL) begin
      pal_mem[idx] = color;
    end else if (mode == MODE_START) begin
      restart_image();
    end else if (mode == MODE_BYTE && !done_flag) begin
      case (cur_phase)
        PH_COUNT: begin
          if (b != 0) begin
            run_len = b;
            cur_phase = PH_COLOR;
          end else begin
            cur_phase = PH_ESCAPE;
          end
        end
        PH_COLOR: begin
          c1 = cfg_nibble ? pal_mem[b[7:4]] : pal_mem[b];
          c2 = cfg_nibble ? pal_mem[b[3:0]] : c1;
          cur_phase = PH_COUNT;
          push_run(run_len, c1, c2);
        end
        PH_ESCAPE: begin
          cur_phase = PH_COUNT;
          if (b == ESC_EOL) begin
            cur_col = 0;
            drop_rows(1);
          end else if (b == ESC_EOB) begin
            done_flag = 1'b1;
            eob = '0;
            eob.eoi = 1'b1;
            pending_writes.push_back(eob);
          end else if (b == ESC_DELTA) begin
            cur_phase = PH_DX;
          end else begin
            abs_left = b;
            pad_flag = abs_bytes(b) % 2;
            cur_phase = PH_ABS;
          end
        end
        PH_DX: begin
          advance_col(b);
          cur_phase = PH_DY;
        end
        PH_DY: begin
          drop_rows(b);
          cur_phase = PH_COUNT;
        end
        PH_ABS: begin
          if (cfg_nibble) begin
            n = (abs_left >= 2) ? 2 : abs_left;
            c1 = pal_mem[b[7:4]];
            c2 = (n == 2) ? pal_mem[b[3:0]] : c1;
          end else begin
            n = 1;
            c1 = pal_mem[b];
            c2 = c1;
          end
          push_run(n, c1, c2);
          abs_left -= n;
          if (abs_left == 0) cur_phase = pad_flag ? PH_PAD : PH_COUNT;
        end
        PH_PAD: begin
          pad_flag = 1'b0;
          cur_phase = PH_COUNT;
        end
        default: cur_phase = PH_COUNT;
      endcase
    end
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] b,
                           logic [BYTE_W-1:0] idx, logic [COLOR_W-1:0] color);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_data_byte <= b;
    in_palette_index <= idx;
    in_palette_color <= color;
    do @(posedge clk); while (!in_ready);
    if (mode != MODE_IGNORED && !(mode == MODE_BYTE && done_flag)) items_sent++;
    decode_item(mode, b, idx, color);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width = val;
      REG_HEIGHT: cfg_height = val;
      REG_NIBBLE: cfg_nibble = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, bit nib);
    wait_drained();
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_NIBBLE, {12'($urandom), nib});
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] b);
    send_item(MODE_BYTE, b, 8'($urandom), $urandom);
  endtask

  task automatic new_image();
    send_item(MODE_START, 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic write_entry(logic [BYTE_W-1:0] idx, logic [COLOR_W-1:0] color);
    send_item(MODE_PAL, 8'($urandom), idx, color);
  endtask

  task automatic run(logic [BYTE_W-1:0] count, logic [BYTE_W-1:0] colour);
    put_byte(count);
    put_byte(colour);
  endtask

  task automatic abs_block(logic [BYTE_W-1:0] count);
    int nbytes;
    nbytes = abs_bytes(count);
    put_byte(ESC_LEAD);
    put_byte(count);
    repeat (nbytes) put_byte(8'($urandom));
    if (nbytes % 2) put_byte(8'($urandom));
  endtask

  task automatic end_line();
    put_byte(ESC_LEAD);
    put_byte(ESC_EOL);
  endtask

  task automatic end_bitmap();
    put_byte(ESC_LEAD);
    put_byte(ESC_EOB);
  endtask

  task automatic skip(logic [BYTE_W-1:0] dx, logic [BYTE_W-1:0] dy);
    put_byte(ESC_LEAD);
    put_byte(ESC_DELTA);
    put_byte(dx);
    put_byte(dy);
  endtask

  task automatic test_palette_load();
    for (int i = 0; i < PAL_DEPTH; i++) begin
      if (i == 0) write_entry(8'(i), '0);
      else if (i == PAL_DEPTH - 1) write_entry(8'(i), '1);
      else write_entry(8'(i), $urandom);
    end
  endtask

  task automatic test_rle8_stream();
    configure(5, 2, 1'b0);
    new_image();
    run(8'd1, 8'h00);
    run(8'd255, 8'hFF);
    abs_block(8'd3);
    skip(8'd1, 8'd0);
    end_line();
    end_line();
    run(8'd2, 8'($urandom));
    end_bitmap();
    put_byte(8'($urandom));
    send_item(MODE_IGNORED, 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic test_rle4_stream();
    configure(8191, 0, 1'b1);
    new_image();
    run(8'd5, 8'hA5);
    abs_block(8'd3);
    abs_block(8'd5);
    run(8'd1, 8'h0F);
    end_bitmap();
  endtask

  task automatic test_saturation();
    configure(MAX_WIDTH, MAX_HEIGHT, 1'b0);
    new_image();
    repeat (33) skip(8'd255, 8'd255);
    run(8'd3, 8'($urandom));
    end_line();
    run(8'd1, 8'($urandom));
    end_bitmap();
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 6))
      0: return 1;
      1: return 0;
      2: return MAX_WIDTH;
      3: return 8191;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(0, 6))
      0: return 1;
      1: return 0;
      2: return MAX_HEIGHT;
      3: return 8191;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic test_random_streams();
    int base;
    int pick;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      configure(pick_width(), pick_height(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) != 0) new_image();
      repeat ($urandom_range(10, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) run(8'($urandom_range(13, 255)), 8'($urandom));
        else if (pick < 45) run(8'($urandom_range(1, 12)), 8'($urandom));
        else if (pick < 58) abs_block(8'($urandom_range(3, 16)));
        else if (pick < 60) abs_block(8'($urandom_range(17, 40)));
        else if (pick < 70) end_line();
        else if (pick < 78) skip(8'($urandom_range(0, 20)), 8'($urandom_range(0, 2)));
        else if (pick < 83) write_entry(8'($urandom), $urandom);
        else if (pick < 87) new_image();
        else if (pick < 91) put_byte(8'($urandom));
        else if (pick < 94) send_item(MODE_IGNORED, 8'($urandom), 8'($urandom), $urandom);
        else if (pick < 96) wait_drained();
        else end_bitmap();
      end
      if ($urandom_range(0, 1) == 0) end_bitmap();
    end
    steady = 1'b0;
  endtask

  task automatic check_field(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_writes
    run_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected run write: address %0h, count %0d", out_start_address,
               out_pixel_count);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        check_field("start_address", want.addr, out_start_address);
        check_field("pixel_count", want.count, out_pixel_count);
        check_field("first_color", want.first, out_first_color);
        check_field("second_color", want.second, out_second_color);
        check_field("end_of_image", want.eoi, out_end_of_image);
        check_field("out_of_range", want.oor, out_out_of_range);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rdy_wait = 0;
    end else begin
      if (out_valid && out_ready) rdy_wait = steady ? 0 : $urandom_range(0, 3);
      else if (rdy_wait > 0) rdy_wait--;
      out_ready <= (rdy_wait == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_PAL;
    in_data_byte <= '0;
    in_palette_index <= '0;
    in_palette_color <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data <= '0;
    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    cfg_nibble = 1'b0;
    steady = 1'b0;
    restart_image();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_palette_load();
    test_rle8_stream();
    test_rle4_stream();
    test_saturation();
    test_random_streams();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[bmp_rle_pixel_decoder_top.f]
rtl/brle_pkg.sv
rtl/brle_palette.sv
rtl/brle_ctrl.sv
rtl/brle_emit.sv
rtl/bmp_rle_pixel_decoder_top.sv
rtl/brle_port_checker.sv
sim/bmp_rle_pixel_decoder_top_test.sv
